// ===== hw/rtl/tce_pkg.sv =====
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types and constants for the CPU execute stage: field widths,
// operation and instruction codes, and the structs passed between modules.
// ----------------------------------------------------------------------------
package tce_pkg;

    // Data path geometry
    localparam int NUM_REGS  = 8;
    localparam int REG_AW    = 3;
    localparam int DATA_W    = 8;
    localparam int INSTR_W   = 20;
    localparam int OP_W      = 2;
    localparam int SEL_W     = 4;
    localparam int IMEM_W    = 9;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Instruction word field positions
    localparam int TYPE_LSB  = 17;
    localparam int DEST_LSB  = 14;
    localparam int SRC_LSB   = 11;
    localparam int TGT_LSB   = 8;

    // Input word operation codes
    localparam logic [OP_W-1:0] OP_EXEC     = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_RET = 2'd1;
    localparam logic [OP_W-1:0] OP_DEBUG    = 2'd2;

    // Instruction types
    localparam logic [2:0] IT_ADD    = 3'd0;
    localparam logic [2:0] IT_ADDI   = 3'd1;
    localparam logic [2:0] IT_MUL    = 3'd2;
    localparam logic [2:0] IT_INV    = 3'd3;
    localparam logic [2:0] IT_BRANCH = 3'd4;
    localparam logic [2:0] IT_LOAD   = 3'd5;
    localparam logic [2:0] IT_STORE  = 3'd6;
    localparam logic [2:0] IT_HALT   = 3'd7;

    // Branch kinds, carried in the dest field
    localparam logic [2:0] BR_EQ = 3'd0;
    localparam logic [2:0] BR_NE = 3'd1;
    localparam logic [2:0] BR_LT = 3'd2;

    // Debug select of the program counter
    localparam logic [SEL_W-1:0] SEL_PC = 4'd0;

    // Configuration register indexes
    localparam logic [0:0] CFG_IMEM_SIZE = 1'b0;
    localparam logic [IMEM_W-1:0] IMEM_SIZE_RST = 9'd256;

    // One accepted input word
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [INSTR_W-1:0] instr_word;
        logic [SEL_W-1:0]   reg_select;
        logic [DATA_W-1:0]  data_value;
    } t_item;

    // One result word
    typedef struct packed {
        logic [DATA_W-1:0] pc_now;
        logic              is_halted;
        logic              read_request;
        logic              write_request;
        logic [DATA_W-1:0] mem_address;
        logic [DATA_W-1:0] write_byte;
        logic              load_waiting;
    } t_result;

    // Register file read request
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] s_addr;
        logic [REG_AW-1:0] t_addr;
    } t_rf_rd;

    // Register file write request
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_rf_wr;

endpackage

// ===== hw/rtl/tce_in_if.sv =====
// ----------------------------------------------------------------------------
// tce_in_if
// Input channel of the execute stage: valid/ready plus one input word.
// ----------------------------------------------------------------------------
interface tce_in_if import tce_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [INSTR_W-1:0] instr_word;
    logic [SEL_W-1:0]   reg_select;
    logic [DATA_W-1:0]  data_value;

    modport source (output valid, op, instr_word, reg_select, data_value, input ready);
    modport sink   (input valid, op, instr_word, reg_select, data_value, output ready);
endinterface

// ===== hw/rtl/tce_out_if.sv =====
// ----------------------------------------------------------------------------
// tce_out_if
// Result channel of the execute stage: valid/ready plus one result word.
// ----------------------------------------------------------------------------
interface tce_out_if import tce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] pc_now;
    logic              is_halted;
    logic              read_request;
    logic              write_request;
    logic [DATA_W-1:0] mem_address;
    logic [DATA_W-1:0] write_byte;
    logic              load_waiting;

    modport source (output valid, pc_now, is_halted, read_request, write_request,
                    mem_address, write_byte, load_waiting, input ready);
    modport sink   (input valid, pc_now, is_halted, read_request, write_request,
                    mem_address, write_byte, load_waiting, output ready);
endinterface

// ===== hw/rtl/tce_cfg.sv =====
// ----------------------------------------------------------------------------
// tce_cfg
// APB configuration register block holding the instruction memory size.
// ----------------------------------------------------------------------------
module tce_cfg import tce_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [IMEM_W-1:0]  o_imem_size
);

    logic [IMEM_W-1:0] r_imem_size;
    logic              wr_en;

    // register index is the word address; byte offset bits are ignored
    assign wr_en  = psel && penable && pwrite && (paddr[PADDR_W-1] == CFG_IMEM_SIZE);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imem_size <= IMEM_SIZE_RST;
        end else if (wr_en) begin
            r_imem_size <= pwdata[IMEM_W-1:0];
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1] == CFG_IMEM_SIZE) begin
            prdata = {{(PDATA_W-IMEM_W){1'b0}}, r_imem_size};
        end
    end

    assign o_imem_size = r_imem_size;

endmodule

// ===== hw/rtl/tce_regfile.sv =====
// ----------------------------------------------------------------------------
// tce_regfile
// Data register file: synchronous memory with two registered read ports,
// one write port, per-entry valid bits for reset, and write forwarding.
// ----------------------------------------------------------------------------
module tce_regfile import tce_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_rf_rd            i_rd,
    input  t_rf_wr            i_wr,
    output logic [DATA_W-1:0] o_sv,
    output logic [DATA_W-1:0] o_tv
);

    logic [DATA_W-1:0]   mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;

    logic [DATA_W-1:0] r_rd_s;
    logic [DATA_W-1:0] r_rd_t;
    logic [REG_AW-1:0] r_ra_s;
    logic [REG_AW-1:0] r_ra_t;
    logic              r_s_ok;
    logic              r_t_ok;

    logic              r_fwd_en;
    logic [REG_AW-1:0] r_fwd_addr;
    logic [DATA_W-1:0] r_fwd_data;

    // storage array and registered read data
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_s <= mem[i_rd.s_addr];
            r_rd_t <= mem[i_rd.t_addr];
            r_ra_s <= i_rd.s_addr;
            r_ra_t <= i_rd.t_addr;
        end
        if (i_wr.en) begin
            r_fwd_addr <= i_wr.addr;
            r_fwd_data <= i_wr.data;
        end
    end

    // valid bits, read-valid flags and forward enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_s_ok   <= 1'b0;
            r_t_ok   <= 1'b0;
            r_fwd_en <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
                r_fwd_en         <= 1'b1;
            end
            if (i_rd.en) begin
                r_s_ok <= r_vld[i_rd.s_addr];
                r_t_ok <= r_vld[i_rd.t_addr];
            end
        end
    end

    // the most recent write wins over a stale read
    always_comb begin
        if (r_fwd_en && (r_fwd_addr == r_ra_s)) begin
            o_sv = r_fwd_data;
        end else begin
            o_sv = r_s_ok ? r_rd_s : '0;
        end
        if (r_fwd_en && (r_fwd_addr == r_ra_t)) begin
            o_tv = r_fwd_data;
        end else begin
            o_tv = r_t_ok ? r_rd_t : '0;
        end
    end

endmodule

// ===== hw/rtl/tce_exec.sv =====
// ----------------------------------------------------------------------------
// tce_exec
// Execute logic: decodes the word, computes the ALU result and branch,
// holds PC, halt and load tracking state, and builds the result word.
// ----------------------------------------------------------------------------
module tce_exec import tce_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_item             i_item,
    input  logic [DATA_W-1:0] i_sv,
    input  logic [DATA_W-1:0] i_tv,
    input  logic [IMEM_W-1:0] i_imem_size,
    output t_rf_wr            o_wr,
    output t_result           o_res
);

    logic [DATA_W-1:0] r_pc;
    logic              r_halt;
    logic              r_lp;
    logic [REG_AW-1:0] r_ldest;

    logic [DATA_W-1:0] n_pc;
    logic              n_halt;
    logic              n_lp;
    logic [REG_AW-1:0] n_ldest;

    logic [2:0]        itype;
    logic [REG_AW-1:0] dest;
    logic [DATA_W-1:0] imm;
    logic [IMEM_W-1:0] pc_inc;
    logic [DATA_W-1:0] pc_adv;
    logic              take;
    logic              br_ok;
    logic              rd_req;
    logic              wr_req;
    logic [DATA_W-1:0] maddr;
    logic [DATA_W-1:0] wbyte;
    t_rf_wr            wr;

    assign itype = i_item.instr_word[TYPE_LSB +: 3];
    assign dest  = i_item.instr_word[DEST_LSB +: REG_AW];
    assign imm   = i_item.instr_word[DATA_W-1:0];

    // PC advance with wrap at the instruction memory size
    assign pc_inc = {1'b0, r_pc} + 9'd1;
    assign pc_adv = (pc_inc < i_imem_size) ? pc_inc[DATA_W-1:0] : '0;

    // decode and execute
    always_comb begin
        n_pc    = r_pc;
        n_halt  = r_halt;
        n_lp    = r_lp;
        n_ldest = r_ldest;
        wr      = '0;
        rd_req  = 1'b0;
        wr_req  = 1'b0;
        maddr   = '0;
        wbyte   = '0;
        take    = 1'b0;
        br_ok   = 1'b0;
        unique case (i_item.op)
            OP_EXEC: begin
                if (!r_halt && !r_lp) begin
                    unique case (itype)
                        IT_ADD: begin
                            wr   = '{en: 1'b1, addr: dest, data: i_sv + i_tv};
                            n_pc = pc_adv;
                        end
                        IT_ADDI: begin
                            wr   = '{en: 1'b1, addr: dest, data: i_sv + imm};
                            n_pc = pc_adv;
                        end
                        IT_MUL: begin
                            wr   = '{en: 1'b1, addr: dest,
                                     data: {4'b0, i_sv[7:4]} * {4'b0, i_sv[3:0]}};
                            n_pc = pc_adv;
                        end
                        IT_INV: begin
                            wr   = '{en: 1'b1, addr: dest, data: ~i_sv};
                            n_pc = pc_adv;
                        end
                        IT_BRANCH: begin
                            case (dest)
                                BR_EQ: begin
                                    br_ok = 1'b1;
                                    take  = (i_sv == i_tv);
                                end
                                BR_NE: begin
                                    br_ok = 1'b1;
                                    take  = (i_sv != i_tv);
                                end
                                BR_LT: begin
                                    br_ok = 1'b1;
                                    take  = (i_sv < i_tv);
                                end
                                default: begin
                                    br_ok = 1'b0;
                                    take  = 1'b0;
                                end
                            endcase
                            // unknown branch kind leaves the PC alone
                            if (br_ok) begin
                                n_pc = take ? imm : pc_adv;
                            end
                        end
                        IT_LOAD: begin
                            rd_req  = 1'b1;
                            maddr   = i_tv;
                            n_lp    = 1'b1;
                            n_ldest = dest;
                        end
                        IT_STORE: begin
                            wr_req = 1'b1;
                            maddr  = i_tv;
                            wbyte  = i_sv;
                            n_pc   = pc_adv;
                        end
                        IT_HALT: begin
                            n_halt = 1'b1;
                            n_pc   = pc_adv;
                        end
                    endcase
                end
            end
            OP_LOAD_RET: begin
                if (r_lp) begin
                    wr   = '{en: 1'b1, addr: r_ldest, data: i_item.data_value};
                    n_lp = 1'b0;
                    n_pc = pc_adv;
                end
            end
            OP_DEBUG: begin
                if (i_item.reg_select == SEL_PC) begin
                    n_pc   = i_item.data_value;
                    n_halt = 1'b0;
                    n_lp   = 1'b0;
                end else if (i_item.reg_select <= SEL_W'(NUM_REGS)) begin
                    wr = '{en: 1'b1, addr: REG_AW'(i_item.reg_select - 4'd1),
                           data: i_item.data_value};
                end
            end
            default: begin
                n_pc = r_pc;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= '0;
            r_halt  <= 1'b0;
            r_lp    <= 1'b0;
            r_ldest <= '0;
        end else if (i_fire) begin
            r_pc    <= n_pc;
            r_halt  <= n_halt;
            r_lp    <= n_lp;
            r_ldest <= n_ldest;
        end
    end

    // write back only when the word retires
    always_comb begin
        o_wr    = wr;
        o_wr.en = wr.en & i_fire;
    end

    assign o_res = '{pc_now:        n_pc,
                     is_halted:     n_halt,
                     read_request:  rd_req,
                     write_request: wr_req,
                     mem_address:   maddr,
                     write_byte:    wbyte,
                     load_waiting:  n_lp};

endmodule

// ===== hw/rtl/tiny_cpu_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// tiny_cpu_instruction_execute
// Stages: stage register (word and register file read), then result
// register; a word executes when the result register is free or draining.
// Throughput: one word per cycle while results are taken, set by the
// registered register file read and write-back with forwarding of the last write.
// Reset: synchronous, active low; clears PC, halt, load tracking, register
// file valid bits (all registers read zero) and sets imem_size to 256.
// ----------------------------------------------------------------------------
module tiny_cpu_instruction_execute import tce_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tce_in_if.sink             i_in,
    tce_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic              r_s1_vld;
    t_item             r_s1_item;
    logic              r_out_vld;
    t_result           r_out;

    logic              in_acc;
    logic              fire;
    logic [IMEM_W-1:0] imem_size;
    logic [DATA_W-1:0] sv;
    logic [DATA_W-1:0] tv;
    t_rf_rd            rf_rd;
    t_rf_wr            rf_wr;
    t_result           res;

    // handshake: execute when the result register is free or draining
    assign fire       = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_s1_vld || fire;
    assign in_acc     = i_in.valid && i_in.ready;

    // register file reads issue as the word is accepted
    assign rf_rd = '{en:     in_acc,
                     s_addr: i_in.instr_word[SRC_LSB +: REG_AW],
                     t_addr: i_in.instr_word[TGT_LSB +: REG_AW]};

    tce_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_imem_size (imem_size)
    );

    tce_regfile u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rf_rd),
        .i_wr    (rf_wr),
        .o_sv    (sv),
        .o_tv    (tv)
    );

    tce_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_s1_item),
        .i_sv        (sv),
        .i_tv        (tv),
        .i_imem_size (imem_size),
        .o_wr        (rf_wr),
        .o_res       (res)
    );

    // stage and result valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (fire) begin
                r_s1_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= '{op:         i_in.op,
                           instr_word: i_in.instr_word,
                           reg_select: i_in.reg_select,
                           data_value: i_in.data_value};
        end
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.pc_now        = r_out.pc_now;
    assign o_out.is_halted     = r_out.is_halted;
    assign o_out.read_request  = r_out.read_request;
    assign o_out.write_request = r_out.write_request;
    assign o_out.mem_address   = r_out.mem_address;
    assign o_out.write_byte    = r_out.write_byte;
    assign o_out.load_waiting  = r_out.load_waiting;

endmodule
